@@ rtl/core/ispdf_pkg.sv @@
`default_nettype none

package ispdf_pkg;

  localparam logic [7:0]  START_MARK       = 8'h46;
  localparam logic [7:0]  SECOND_MARK      = 8'hB9;
  localparam logic [7:0]  DIR_RESET        = 8'h68;
  localparam logic [15:0] MIN_FRAME_LENGTH = 16'd6;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_MARKER  = 4'd1,
    PH_DIR     = 4'd2,
    PH_LEN_HI  = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CK_HI   = 4'd6,
    PH_CK_LO   = 4'd7,
    PH_STOP    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CK_FAIL   = 2'd1,
    ST_SHORT_LEN = 2'd2
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic       marker_warning;
    logic       direction_warning;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ispdf_parse.sv @@
`default_nettype none

module ispdf_parse import ispdf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] expected_direction,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] ck_r, ck_nxt;
  logic [1:0]  warn_r, warn_nxt;
  logic [15:0] frame_length;

  assign frame_length = {len_hi_r, rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      len_hi_r     <= '0;
      bytes_left_r <= '0;
      sum_r        <= '0;
      ck_r         <= '0;
      warn_r       <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      len_hi_r     <= len_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
      ck_r         <= ck_nxt;
      warn_r       <= warn_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    len_hi_nxt     = len_hi_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    ck_nxt         = ck_r;
    warn_nxt       = warn_r;
    res_valid      = 1'b0;
    res            = '0;
    res.item_kind  = KIND_STATUS;
    res.marker_warning    = warn_r[0];
    res.direction_warning = warn_r[1];
    case (phase_r)
      PH_MARKER: begin
        if (rx_byte != SECOND_MARK) warn_nxt[0] = 1'b1;
        phase_nxt = PH_DIR;
      end
      PH_DIR: begin
        if (rx_byte != expected_direction) warn_nxt[1] = 1'b1;
        sum_nxt   = {8'd0, rx_byte};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi_nxt = rx_byte;
        sum_nxt    = sum_r + {8'd0, rx_byte};
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_nxt = sum_r + {8'd0, rx_byte};
        if (frame_length < MIN_FRAME_LENGTH) begin
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.frame_status = ST_SHORT_LEN;
        end else begin
          bytes_left_nxt = frame_length - MIN_FRAME_LENGTH;
          phase_nxt = (frame_length == MIN_FRAME_LENGTH) ? PH_CK_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt        = sum_r + {8'd0, rx_byte};
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) phase_nxt = PH_CK_HI;
        res_valid = 1'b1;
        res       = '0;
        res.item_kind    = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
      end
      PH_CK_HI: begin
        ck_nxt    = {rx_byte, 8'd0};
        phase_nxt = PH_CK_LO;
      end
      PH_CK_LO: begin
        ck_nxt    = {ck_r[15:8], rx_byte};
        phase_nxt = PH_STOP;
      end
      PH_STOP: begin
        phase_nxt        = PH_HUNT;
        res_valid        = 1'b1;
        res.frame_status = (ck_r == sum_r) ? ST_OK : ST_CK_FAIL;
      end
      default: begin
        // Hunting; any unreachable phase code lands here as well.
        phase_nxt = PH_HUNT;
        if (rx_byte == START_MARK) begin
          warn_nxt  = '0;
          phase_nxt = PH_MARKER;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/isp_packet_deframer_top.sv @@
// Packet deframer for a byte stream with a 16-bit byte-sum checksum.
// The input channel (in_valid, in_stall, in_rx_byte) takes one received byte
// per request. The block hunts for the start byte, checks the marker and the
// direction byte, reads a big-endian frame length, and forwards each payload
// byte as a result request with out_item_kind low. After the checksum and
// stop bytes it sends one status request with out_item_kind high, carrying
// the frame status and the marker and direction warnings. A frame length
// below six ends the frame early with a length-error status.
// A received byte passes through the input register and the parser into the
// result register, which drives out_valid; one byte can be accepted every
// cycle while out_stall is low, set by the single input register feeding the
// parser and the single result register behind it.
// The configuration channel (cfg_valid, cfg_ready, cfg_expected_direction)
// sets the expected direction byte; cfg_ready is always high.
// Synchronous reset returns the parser to hunting, empties both registers
// and restores the expected direction to 0x68.
// When the receiver raises out_stall the result request holds, the input
// register fills and then in_stall rises; no request is lost.
`default_nettype none

module isp_packet_deframer_top import ispdf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_item_kind,
  output logic [7:0]      out_payload_byte,
  output logic [1:0]      out_frame_status,
  output logic            out_marker_warning,
  output logic            out_direction_warning,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_expected_direction
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       out_vld_r, out_vld_nxt;
  result_t    out_r;
  logic [7:0] exp_dir_r;
  logic       fire;
  logic       in_accept;
  logic       res_valid;
  result_t    res;

  // The held byte moves on whenever the result register is free or drains.
  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = res_valid;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      exp_dir_r <= DIR_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) exp_dir_r <= cfg_expected_direction;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_byte_r <= in_rx_byte;
    if (fire && res_valid) out_r <= res;
  end

  ispdf_parse u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .rx_byte            (in_byte_r),
    .expected_direction (exp_dir_r),
    .res_valid          (res_valid),
    .res                (res)
  );

  assign out_valid             = out_vld_r;
  assign out_item_kind         = out_r.item_kind;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_frame_status      = out_r.frame_status;
  assign out_marker_warning    = out_r.marker_warning;
  assign out_direction_warning = out_r.direction_warning;

  // A payload request carries no status or warnings.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.item_kind == KIND_PAYLOAD |->
      out_r.frame_status == ST_OK && !out_r.marker_warning &&
      !out_r.direction_warning)
    else $error("payload request carries status bits");

  // A status request never carries payload data or an undefined code.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.item_kind == KIND_STATUS |->
      out_r.payload_byte == 8'd0 && out_r.frame_status != 2'd3)
    else $error("malformed status request");

  // The input side only stalls while a byte is held and cannot advance.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

  // A byte that cannot move stays in the input register.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r && $stable(in_byte_r))
    else $error("held input byte lost");

endmodule

`default_nettype wire
